FILE: hw/rtl/assert_macros.svh
// assertion helpers shared by wsd_front, wsd_queue and wsd_back
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every rising clock edge out of reset
`define WSD_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// same-cycle implication
`define WSD_ASSERT_IMPL(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

`endif

FILE: hw/rtl/wsd_pkg.sv
// ----------------------------------------------------------------------------
// wsd_pkg
// shared types and constants of the websocket frame deframer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package wsd_pkg;

    localparam int MAX_CONTROL_PAYLOAD = 125;
    localparam int QUEUE_DEPTH         = 4;

    localparam int MAX_LENGTH_W = 41;
    localparam int CFG_INDEX_W  = 2;
    localparam int LENGTH_W     = 64;

    localparam logic [MAX_LENGTH_W-1:0] MAX_LENGTH_RESET = 41'h100_0000_0000;

    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_LENGTH   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_REQUIRE_MASK = 2'd1;

    localparam logic [2:0] KIND_TEXT  = 3'd0;
    localparam logic [2:0] KIND_PONG  = 3'd1;
    localparam logic [2:0] KIND_CLOSE = 3'd2;
    localparam logic [2:0] KIND_ERROR = 3'd3;
    localparam logic [2:0] KIND_EMPTY = 3'd4;

    localparam logic [2:0] ERR_NONE        = 3'd0;
    localparam logic [2:0] ERR_UNMASKED    = 3'd1;
    localparam logic [2:0] ERR_TOO_LONG    = 3'd2;
    localparam logic [2:0] ERR_BAD_OPCODE  = 3'd3;
    localparam logic [2:0] ERR_PING_LENGTH = 3'd4;

    localparam logic [3:0] OPC_TEXT  = 4'h1;
    localparam logic [3:0] OPC_CLOSE = 4'h8;
    localparam logic [3:0] OPC_PING  = 4'h9;
    localparam logic [3:0] OPC_PONG  = 4'ha;

    localparam logic [6:0] LEN_EXT16 = 7'd126;
    localparam logic [6:0] LEN_EXT64 = 7'd127;

    localparam logic [7:0] PONG_HEADER_BYTE = 8'h8a;

    typedef enum logic [2:0] {
        PH_OPCODE,
        PH_LEN,
        PH_EXTLEN,
        PH_MASK,
        PH_PAYLOAD
    } phase_t;

    typedef enum logic [2:0] {
        CMD_TEXT,
        CMD_PONG,
        CMD_CLOSE,
        CMD_ERROR,
        CMD_EMPTY,
        CMD_PING_HDR
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t    op;
        logic [7:0] data;
        logic       last;
        logic [2:0] err;
    } cmd_t;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] data;
        logic       last;
        logic [2:0] err;
    } res_t;

    typedef struct packed {
        logic [MAX_LENGTH_W-1:0] max_length;
        logic                    require_mask;
    } cfg_t;

endpackage

`default_nettype wire

FILE: hw/rtl/websocket_frame_deframer_top.sv
// ----------------------------------------------------------------------------
// websocket_frame_deframer_top
// client-to-server websocket frame parser with queue-style ports
// ----------------------------------------------------------------------------
// Takes one received byte per clock while full is low. A byte's result item
// passes through the command queue and the result register and is held on
// the result ports until popped. Most bytes give at most one item; the byte
// that completes a ping header gives two (0x8a and the length), and the
// command queue between parser and result stage absorbs the extra item.
// Sustained rate is one byte per cycle when pop is kept high. A close frame
// or any error stops the parser until reset; later bytes are accepted and
// dropped. Configuration is written through cfg_we/cfg_index/cfg_data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module websocket_frame_deframer_top #(
    parameter int QUEUE_DEPTH = wsd_pkg::QUEUE_DEPTH
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [wsd_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [wsd_pkg::MAX_LENGTH_W-1:0] cfg_data,
    input  wire logic                             push,
    output logic                                  full,
    input  wire logic [7:0]                       rx_byte,
    input  wire logic                             pop,
    output logic                                  empty,
    output logic [2:0]                            kind,
    output logic [7:0]                            data_byte,
    output logic                                  last,
    output logic [2:0]                            error_code
);

    wsd_pkg::cfg_t cfg_reg;
    wsd_pkg::cmd_t cmd;
    wsd_pkg::cmd_t q_data;
    wsd_pkg::res_t res;
    logic          cmd_push;
    logic          q_pop;
    logic          q_empty;
    logic          in_accept;

    assign in_accept = push && !full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_length   <= wsd_pkg::MAX_LENGTH_RESET;
            cfg_reg.require_mask <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                wsd_pkg::CFG_MAX_LENGTH:   cfg_reg.max_length   <= cfg_data;
                wsd_pkg::CFG_REQUIRE_MASK: cfg_reg.require_mask <= cfg_data[0];
                default:                   cfg_reg              <= cfg_reg;
            endcase
        end
    end

    wsd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_accept (in_accept),
        .rx_byte   (rx_byte),
        .cmd_push  (cmd_push),
        .cmd       (cmd)
    );

    wsd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cmd_push),
        .wr_data (cmd),
        .rd_en   (q_pop),
        .rd_data (q_data),
        .full    (full),
        .empty   (q_empty)
    );

    wsd_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_data  (q_data),
        .q_pop   (q_pop),
        .pop     (pop),
        .empty   (empty),
        .res     (res)
    );

    assign kind       = res.kind;
    assign data_byte  = res.data;
    assign last       = res.last;
    assign error_code = res.err;

endmodule

`default_nettype wire

FILE: hw/rtl/wsd_front.sv
// ----------------------------------------------------------------------------
// wsd_front
// header parser and payload unmasking, at most one command per accepted byte
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module wsd_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire wsd_pkg::cfg_t cfg,
    input  wire logic          in_accept,
    input  wire logic [7:0]    rx_byte,
    output logic               cmd_push,
    output wsd_pkg::cmd_t      cmd
);

    wsd_pkg::phase_t                phase_reg, phase_next;
    logic [3:0]                     opcode_reg, opcode_next;
    logic [3:0]                     hbl_reg, hbl_next;
    logic [wsd_pkg::LENGTH_W-1:0]   rem_reg, rem_next;
    logic [31:0]                    key_reg, key_next;
    logic [1:0]                     pos_reg, pos_next;
    logic                           halted_reg, halted_next;
    logic                           mask_seen_reg, mask_seen_next;
    logic                           long_reg, long_next;

    logic                           len_done;
    logic                           len_was64;
    logic                           begin_pl;
    logic [wsd_pkg::LENGTH_W-1:0]   rem_cand;
    logic                           mask_cand;
    logic [1:0]                     key_idx;
    logic [7:0]                     pay_byte;
    logic [wsd_pkg::LENGTH_W-1:0]   rem_dec;
    logic [3:0]                     hbl_dec;

    always_comb
    begin
        key_idx  = 2'd0 - hbl_reg[1:0];
        pay_byte = rx_byte ^ key_reg[{pos_reg, 3'b000} +: 8];
        rem_dec  = rem_reg - 64'd1;
        hbl_dec  = hbl_reg - 4'd1;
    end

    always_comb
    begin
        phase_next     = phase_reg;
        opcode_next    = opcode_reg;
        hbl_next       = hbl_reg;
        rem_next       = rem_reg;
        key_next       = key_reg;
        pos_next       = pos_reg;
        halted_next    = halted_reg;
        mask_seen_next = mask_seen_reg;
        long_next      = long_reg;
        cmd_push       = 1'b0;
        cmd            = '{op: wsd_pkg::CMD_TEXT, data: 8'd0, last: 1'b0,
                           err: wsd_pkg::ERR_NONE};
        len_done       = 1'b0;
        len_was64      = 1'b0;
        begin_pl       = 1'b0;
        rem_cand       = rem_reg;
        mask_cand      = mask_seen_reg;

        if (in_accept && !halted_reg)
        begin
            case (phase_reg)
                wsd_pkg::PH_OPCODE:
                begin
                    opcode_next = rx_byte[3:0];
                    if (rx_byte[3:0] == wsd_pkg::OPC_CLOSE)
                    begin
                        halted_next = 1'b1;
                        cmd_push    = 1'b1;
                        cmd.op      = wsd_pkg::CMD_CLOSE;
                    end
                    else if (rx_byte[3:0] != wsd_pkg::OPC_TEXT &&
                             rx_byte[3:0] != wsd_pkg::OPC_PING &&
                             rx_byte[3:0] != wsd_pkg::OPC_PONG)
                    begin
                        halted_next = 1'b1;
                        cmd_push    = 1'b1;
                        cmd.op      = wsd_pkg::CMD_ERROR;
                        cmd.err     = wsd_pkg::ERR_BAD_OPCODE;
                    end
                    else
                    begin
                        phase_next = wsd_pkg::PH_LEN;
                    end
                end
                wsd_pkg::PH_LEN:
                begin
                    mask_cand      = rx_byte[7];
                    mask_seen_next = rx_byte[7];
                    if (rx_byte[6:0] == wsd_pkg::LEN_EXT16 ||
                        rx_byte[6:0] == wsd_pkg::LEN_EXT64)
                    begin
                        long_next  = (rx_byte[6:0] == wsd_pkg::LEN_EXT64);
                        hbl_next   = (rx_byte[6:0] == wsd_pkg::LEN_EXT64) ? 4'd8 : 4'd2;
                        rem_next   = '0;
                        phase_next = wsd_pkg::PH_EXTLEN;
                    end
                    else
                    begin
                        long_next = 1'b0;
                        rem_cand  = {57'd0, rx_byte[6:0]};
                        rem_next  = rem_cand;
                        len_done  = 1'b1;
                    end
                end
                wsd_pkg::PH_EXTLEN:
                begin
                    rem_cand = {rem_reg[wsd_pkg::LENGTH_W-9:0], rx_byte};
                    rem_next = rem_cand;
                    hbl_next = hbl_dec;
                    if (hbl_dec == 4'd0)
                    begin
                        len_done  = 1'b1;
                        len_was64 = long_reg;
                    end
                end
                wsd_pkg::PH_MASK:
                begin
                    key_next[{key_idx, 3'b000} +: 8] =
                        key_reg[{key_idx, 3'b000} +: 8] | rx_byte;
                    hbl_next = hbl_dec;
                    if (hbl_dec == 4'd0)
                    begin
                        begin_pl = 1'b1;
                    end
                end
                wsd_pkg::PH_PAYLOAD:
                begin
                    pos_next = pos_reg + 2'd1;
                    rem_next = rem_dec;
                    if (rem_dec == '0)
                    begin
                        phase_next = wsd_pkg::PH_OPCODE;
                    end
                    cmd.data = pay_byte;
                    cmd.last = (rem_dec == '0);
                    if (opcode_reg == wsd_pkg::OPC_TEXT)
                    begin
                        cmd_push = 1'b1;
                        cmd.op   = wsd_pkg::CMD_TEXT;
                    end
                    else if (opcode_reg == wsd_pkg::OPC_PING)
                    begin
                        cmd_push = 1'b1;
                        cmd.op   = wsd_pkg::CMD_PONG;
                    end
                end
                default:
                begin
                    phase_next = wsd_pkg::PH_OPCODE;
                end
            endcase
        end

        if (len_done)
        begin
            if (len_was64 && rem_cand > {23'd0, cfg.max_length})
            begin
                halted_next = 1'b1;
                cmd_push    = 1'b1;
                cmd.op      = wsd_pkg::CMD_ERROR;
                cmd.err     = wsd_pkg::ERR_TOO_LONG;
            end
            else if (!mask_cand && cfg.require_mask)
            begin
                halted_next = 1'b1;
                cmd_push    = 1'b1;
                cmd.op      = wsd_pkg::CMD_ERROR;
                cmd.err     = wsd_pkg::ERR_UNMASKED;
            end
            else if (opcode_reg == wsd_pkg::OPC_PING &&
                     rem_cand > 64'(wsd_pkg::MAX_CONTROL_PAYLOAD))
            begin
                halted_next = 1'b1;
                cmd_push    = 1'b1;
                cmd.op      = wsd_pkg::CMD_ERROR;
                cmd.err     = wsd_pkg::ERR_PING_LENGTH;
            end
            else
            begin
                key_next = '0;
                if (mask_cand)
                begin
                    phase_next = wsd_pkg::PH_MASK;
                    hbl_next   = 4'd4;
                end
                else
                begin
                    begin_pl = 1'b1;
                end
            end
        end

        if (begin_pl)
        begin
            pos_next   = 2'd0;
            phase_next = (rem_cand == '0) ? wsd_pkg::PH_OPCODE : wsd_pkg::PH_PAYLOAD;
            if (opcode_reg == wsd_pkg::OPC_PING)
            begin
                cmd_push = 1'b1;
                cmd.op   = wsd_pkg::CMD_PING_HDR;
                cmd.data = {1'b0, rem_cand[6:0]};
                cmd.last = (rem_cand == '0);
            end
            else if (opcode_reg == wsd_pkg::OPC_TEXT && rem_cand == '0)
            begin
                cmd_push = 1'b1;
                cmd.op   = wsd_pkg::CMD_EMPTY;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= wsd_pkg::PH_OPCODE;
            opcode_reg    <= 4'd0;
            hbl_reg       <= 4'd0;
            rem_reg       <= '0;
            key_reg       <= 32'd0;
            pos_reg       <= 2'd0;
            halted_reg    <= 1'b0;
            mask_seen_reg <= 1'b0;
            long_reg      <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            opcode_reg    <= opcode_next;
            hbl_reg       <= hbl_next;
            rem_reg       <= rem_next;
            key_reg       <= key_next;
            pos_reg       <= pos_next;
            halted_reg    <= halted_next;
            mask_seen_reg <= mask_seen_next;
            long_reg      <= long_next;
        end
    end

    `WSD_ASSERT_IMPL(a_halted_silent, clk, rst_n, halted_reg, !cmd_push, "command after halt")

endmodule

`default_nettype wire

FILE: hw/rtl/wsd_queue.sv
// ----------------------------------------------------------------------------
// wsd_queue
// small register queue of commands between parser and result stage
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module wsd_queue #(
    parameter int DEPTH = wsd_pkg::QUEUE_DEPTH
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          wr_en,
    input  wire wsd_pkg::cmd_t wr_data,
    input  wire logic          rd_en,
    output wsd_pkg::cmd_t      rd_data,
    output logic               full,
    output logic               empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    wsd_pkg::cmd_t    mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr;
    logic             do_rd;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `WSD_ASSERT(a_count_bound, clk, rst_n, count_reg <= CNT_W'(DEPTH), "queue count overflow")

endmodule

`default_nettype wire

FILE: hw/rtl/wsd_back.sv
// ----------------------------------------------------------------------------
// wsd_back
// result stage: expands commands into result items behind an output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module wsd_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          q_empty,
    input  wire wsd_pkg::cmd_t q_data,
    output logic               q_pop,
    input  wire logic          pop,
    output logic               empty,
    output wsd_pkg::res_t      res
);

    logic           valid_reg, valid_next;
    logic           second_reg, second_next;
    wsd_pkg::res_t  res_reg, res_next;
    logic           load_ok;
    logic           head_is_hdr;

    assign empty       = !valid_reg;
    assign res         = res_reg;
    assign load_ok     = !valid_reg || pop;
    assign head_is_hdr = !q_empty && q_data.op == wsd_pkg::CMD_PING_HDR;

    always_comb
    begin
        valid_next  = valid_reg;
        second_next = second_reg;
        res_next    = res_reg;
        q_pop       = 1'b0;
        if (load_ok)
        begin
            valid_next = second_reg || !q_empty;
            if (second_reg)
            begin
                // length byte of the pong header
                res_next    = '{kind: wsd_pkg::KIND_PONG, data: q_data.data,
                                last: q_data.last, err: wsd_pkg::ERR_NONE};
                second_next = 1'b0;
                q_pop       = 1'b1;
            end
            else if (!q_empty)
            begin
                res_next = '{kind: wsd_pkg::KIND_TEXT, data: q_data.data,
                             last: q_data.last, err: q_data.err};
                q_pop    = 1'b1;
                case (q_data.op)
                    wsd_pkg::CMD_TEXT:  res_next.kind = wsd_pkg::KIND_TEXT;
                    wsd_pkg::CMD_PONG:  res_next.kind = wsd_pkg::KIND_PONG;
                    wsd_pkg::CMD_CLOSE: res_next.kind = wsd_pkg::KIND_CLOSE;
                    wsd_pkg::CMD_ERROR: res_next.kind = wsd_pkg::KIND_ERROR;
                    wsd_pkg::CMD_EMPTY: res_next.kind = wsd_pkg::KIND_EMPTY;
                    wsd_pkg::CMD_PING_HDR:
                    begin
                        res_next    = '{kind: wsd_pkg::KIND_PONG,
                                        data: wsd_pkg::PONG_HEADER_BYTE,
                                        last: 1'b0, err: wsd_pkg::ERR_NONE};
                        second_next = 1'b1;
                        q_pop       = 1'b0;
                    end
                    default:            res_next.kind = wsd_pkg::KIND_ERROR;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= 1'b0;
            second_reg <= 1'b0;
        end
        else
        begin
            valid_reg  <= valid_next;
            second_reg <= second_next;
        end
    end

    `WSD_ASSERT_IMPL(a_second_head, clk, rst_n, second_reg, head_is_hdr, "pong header lost")

endmodule

`default_nettype wire

FILE: verif/tb_websocket_frame_deframer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_websocket_frame_deframer_top
// Testbench for the websocket frame deframer. A driver pushes received bytes
// from a queue of pending items and a parser model of its own predicts the
// deframed result items. A monitor pops result items at a random pace and
// compares each with the oldest prediction. Settings are changed between
// phases once the block has drained. Each run closes with one randomly
// chosen frame that halts the block, followed by ignored bytes.
// ----------------------------------------------------------------------------

module tb_websocket_frame_deframer_top;

    import wsd_pkg::*;

    localparam int WATCHDOG_LIMIT = 200;
    localparam int RANDOM_ITEMS   = 1350;

    typedef enum {FORM_7, FORM_16, FORM_64} len_form_t;
    typedef enum {END_CLOSE, END_UNMASKED, END_TOO_LONG, END_BAD_OPCODE, END_PING_LENGTH}
        ending_t;

    logic                    clk       = 1'b0;
    logic                    rst_n     = 1'b0;
    logic                    cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0]  cfg_index = '0;
    logic [MAX_LENGTH_W-1:0] cfg_data  = '0;
    logic                    push      = 1'b0;
    logic [7:0]              rx_byte   = 8'h00;
    logic                    pop       = 1'b0;
    logic                    full;
    logic                    empty;
    logic [2:0]              kind;
    logic [7:0]              data_byte;
    logic                    last;
    logic [2:0]              error_code;

    websocket_frame_deframer_top DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .push       (push),
        .full       (full),
        .rx_byte    (rx_byte),
        .pop        (pop),
        .empty      (empty),
        .kind       (kind),
        .data_byte  (data_byte),
        .last       (last),
        .error_code (error_code)
    );

    always #1 clk = ~clk;

    logic [7:0] stream_bytes[$];
    res_t       expected_deframed[$];
    int         bytes_queued = 0;
    int         mismatches   = 0;
    bit         sender_calm  = 1'b0;
    bit         receiver_calm = 1'b0;
    int         send_gap     = 0;
    int         pop_hold     = 0;
    int         pop_draw;
    int         stalled_cycles = 0;
    res_t       want_item;
    res_t       got_item;

    // parser model state and its copy of the settings
    phase_t                  prs_phase;
    logic [3:0]              prs_opcode;
    logic [3:0]              prs_hdr_left;
    logic [63:0]             prs_remaining;
    logic [31:0]             prs_key;
    logic [1:0]              prs_key_pos;
    logic                    prs_halted;
    logic                    prs_masked;
    logic                    prs_long;
    logic [MAX_LENGTH_W-1:0] cfg_max_length;
    logic                    cfg_require_mask;

    function automatic void reset_parser();
        prs_phase        = PH_OPCODE;
        prs_opcode       = '0;
        prs_hdr_left     = '0;
        prs_remaining    = '0;
        prs_key          = '0;
        prs_key_pos      = '0;
        prs_halted       = 1'b0;
        prs_masked       = 1'b0;
        prs_long         = 1'b0;
        cfg_max_length   = MAX_LENGTH_RESET;
        cfg_require_mask = 1'b1;
    endfunction

    function automatic void add_result(logic [2:0] k, logic [7:0] d, logic l, logic [2:0] e);
        expected_deframed.insert(expected_deframed.size(), res_t'{k, d, l, e});
    endfunction

    function automatic void halt_with(logic [2:0] e);
        prs_halted = 1'b1;
        add_result(KIND_ERROR, 8'h00, 1'b0, e);
    endfunction

    function automatic void start_payload();
        prs_key_pos = '0;
        if (prs_opcode == OPC_PING)
        begin
            add_result(KIND_PONG, PONG_HEADER_BYTE, 1'b0, ERR_NONE);
            add_result(KIND_PONG, {1'b0, prs_remaining[6:0]}, prs_remaining == 0, ERR_NONE);
        end
        else if (prs_opcode == OPC_TEXT && prs_remaining == 0)
        begin
            add_result(KIND_EMPTY, 8'h00, 1'b0, ERR_NONE);
        end
        prs_phase = (prs_remaining == 0) ? PH_OPCODE : PH_PAYLOAD;
    endfunction

    function automatic void finish_length(logic was64);
        if (was64 && prs_remaining > 64'(cfg_max_length))
            halt_with(ERR_TOO_LONG);
        else if (!prs_masked && cfg_require_mask)
            halt_with(ERR_UNMASKED);
        else if (prs_opcode == OPC_PING && prs_remaining > 64'(MAX_CONTROL_PAYLOAD))
            halt_with(ERR_PING_LENGTH);
        else
        begin
            prs_key = '0;
            if (prs_masked)
            begin
                prs_phase    = PH_MASK;
                prs_hdr_left = 4'd4;
            end
            else
            begin
                start_payload();
            end
        end
    endfunction

    function automatic void parse_rx_byte(logic [7:0] b);
        logic [7:0] plain;
        logic       fin;
        if (prs_halted)
            return;
        case (prs_phase)
            PH_OPCODE:
            begin
                prs_opcode = b[3:0];
                if (prs_opcode == OPC_CLOSE)
                begin
                    prs_halted = 1'b1;
                    add_result(KIND_CLOSE, 8'h00, 1'b0, ERR_NONE);
                end
                else if (prs_opcode != OPC_TEXT && prs_opcode != OPC_PING &&
                         prs_opcode != OPC_PONG)
                begin
                    halt_with(ERR_BAD_OPCODE);
                end
                else
                begin
                    prs_phase = PH_LEN;
                end
            end
            PH_LEN:
            begin
                prs_masked    = b[7];
                prs_remaining = '0;
                if (b[6:0] == LEN_EXT16 || b[6:0] == LEN_EXT64)
                begin
                    prs_long     = (b[6:0] == LEN_EXT64);
                    prs_hdr_left = prs_long ? 4'd8 : 4'd2;
                    prs_phase    = PH_EXTLEN;
                end
                else
                begin
                    prs_long      = 1'b0;
                    prs_remaining = 64'(b[6:0]);
                    finish_length(1'b0);
                end
            end
            PH_EXTLEN:
            begin
                prs_remaining = {prs_remaining[55:0], b};
                prs_hdr_left  = prs_hdr_left - 4'd1;
                if (prs_hdr_left == 0)
                    finish_length(prs_long);
            end
            PH_MASK:
            begin
                prs_key      = prs_key | (32'(b) << (8 * (4 - int'(prs_hdr_left))));
                prs_hdr_left = prs_hdr_left - 4'd1;
                if (prs_hdr_left == 0)
                    start_payload();
            end
            PH_PAYLOAD:
            begin
                plain         = b ^ prs_key[8 * prs_key_pos +: 8];
                prs_key_pos   = prs_key_pos + 2'd1;
                prs_remaining = prs_remaining - 64'd1;
                fin           = (prs_remaining == 0);
                if (fin)
                    prs_phase = PH_OPCODE;
                if (prs_opcode == OPC_TEXT)
                    add_result(KIND_TEXT, plain, fin, ERR_NONE);
                else if (prs_opcode == OPC_PING)
                    add_result(KIND_PONG, plain, fin, ERR_NONE);
            end
            default:
            begin
                prs_phase = PH_OPCODE;
            end
        endcase
    endfunction

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [MAX_LENGTH_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        if (idx == CFG_MAX_LENGTH)
            cfg_max_length = val;
        else if (idx == CFG_REQUIRE_MASK)
            cfg_require_mask = val[0];
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_settings();
        logic [MAX_LENGTH_W-1:0] ml;
        sender_calm   = ($urandom_range(0, 3) == 0);
        receiver_calm = ($urandom_range(0, 3) == 0);
        case ($urandom_range(0, 3))
            0:       ml = '0;
            1:       ml = MAX_LENGTH_W'($urandom_range(0, 40));
            2:       ml = MAX_LENGTH_RESET;
            default: ml = {1'b0, 8'($urandom), 32'($urandom)};
        endcase
        write_reg(CFG_MAX_LENGTH, ml);
        write_reg(CFG_REQUIRE_MASK, {40'({$urandom_range(0, 255), $urandom}),
                                     1'($urandom_range(0, 1))});
        if ($urandom_range(0, 3) == 0)
            write_reg(CFG_REQUIRE_MASK + CFG_INDEX_W'($urandom_range(1, 2)),
                      MAX_LENGTH_W'({$urandom, $urandom}));
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (stream_bytes.size() != 0 || push || expected_deframed.size() != 0);
        repeat (8) @(negedge clk);
    endtask

    task automatic queue_byte(input logic [7:0] b);
        stream_bytes.insert(stream_bytes.size(), b);
        bytes_queued++;
    endtask

    function automatic logic [3:0] pick_data_opcode();
        case ($urandom_range(0, 3))
            0, 1:    return OPC_TEXT;
            2:       return OPC_PING;
            default: return OPC_PONG;
        endcase
    endfunction

    task automatic queue_frame(input logic [3:0] opc, input logic [63:0] len,
                               input len_form_t form, input bit masked,
                               input logic [31:0] key, input bit with_payload);
        queue_byte({4'($urandom), opc});
        case (form)
            FORM_7:
            begin
                queue_byte({masked, len[6:0]});
            end
            FORM_16:
            begin
                queue_byte({masked, LEN_EXT16});
                queue_byte(len[15:8]);
                queue_byte(len[7:0]);
            end
            default:
            begin
                queue_byte({masked, LEN_EXT64});
                for (int i = 7; i >= 0; i--)
                    queue_byte(len[8 * i +: 8]);
            end
        endcase
        if (masked)
            for (int i = 0; i < 4; i++)
                queue_byte(key[8 * i +: 8]);
        if (with_payload)
            for (longint i = 0; i < len; i++)
                queue_byte(8'($urandom));
    endtask

    task automatic queue_random_frame();
        logic [3:0]  opc;
        logic [63:0] len;
        len_form_t   form;
        bit          masked;
        logic [31:0] key;
        int          r;
        opc = pick_data_opcode();
        r = $urandom_range(0, 99);
        if (r < 70)
            len = $urandom_range(0, 15);
        else if (r < 90 || opc == OPC_PING)
            len = $urandom_range(16, MAX_CONTROL_PAYLOAD);
        else
            len = $urandom_range(MAX_CONTROL_PAYLOAD + 1, 300);
        if (opc == OPC_PING && $urandom_range(0, 9) == 0)
            len = MAX_CONTROL_PAYLOAD;
        if (cfg_max_length < 64 && $urandom_range(0, 3) == 0)
            len = 64'(cfg_max_length);
        r = $urandom_range(0, 4);
        if (r == 4 && len <= 64'(cfg_max_length))
            form = FORM_64;
        else if (r == 3 || len > MAX_CONTROL_PAYLOAD)
            form = FORM_16;
        else
            form = FORM_7;
        masked = cfg_require_mask ? 1'b1 : 1'($urandom_range(0, 1));
        r = $urandom_range(0, 9);
        key = (r == 0) ? 32'h0 : (r == 1) ? 32'hffff_ffff : 32'($urandom);
        queue_frame(opc, len, form, masked, key, 1'b1);
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push     <= 1'b0;
            send_gap <= 0;
        end
        else
        begin
            if (push && !full)
                parse_rx_byte(rx_byte);
            if (!(push && full))
            begin
                if (send_gap != 0)
                begin
                    push     <= 1'b0;
                    send_gap <= send_gap - 1;
                end
                else if (stream_bytes.size() != 0)
                begin
                    push     <= 1'b1;
                    rx_byte  <= stream_bytes.pop_front();
                    send_gap <= sender_calm ? 0 : $urandom_range(0, 7);
                end
                else
                begin
                    push <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pop      <= 1'b0;
            pop_hold <= 0;
        end
        else if (pop && !empty)
        begin
            got_item = '{kind, data_byte, last, error_code};
            if (expected_deframed.size() == 0)
            begin
                $display("%0t: unexpected item: expected none, ", $time,
                         "actual kind %0d data %02h last %0d err %0d",
                         got_item.kind, got_item.data, got_item.last, got_item.err);
                mismatches++;
            end
            else
            begin
                want_item = expected_deframed.pop_front();
                if (got_item !== want_item)
                begin
                    $display("%0t: mismatch: ", $time,
                             "expected kind %0d data %02h last %0d err %0d, ",
                             want_item.kind, want_item.data, want_item.last,
                             want_item.err,
                             "actual kind %0d data %02h last %0d err %0d",
                             got_item.kind, got_item.data, got_item.last,
                             got_item.err);
                    mismatches++;
                end
            end
            pop_draw = receiver_calm ? 0 : $urandom_range(0, 7);
            pop      <= (pop_draw == 0);
            pop_hold <= pop_draw;
        end
        else if (!pop)
        begin
            if (pop_hold > 1)
            begin
                pop_hold <= pop_hold - 1;
            end
            else
            begin
                pop      <= 1'b1;
                pop_hold <= 0;
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty))
                stalled_cycles <= 0;
            else
                stalled_cycles <= stalled_cycles + 1;
            if (stalled_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: watchdog: no item moved for %0d cycles", $time, stalled_cycles);
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial
    begin
        ending_t     ending;
        int          phase_end;
        logic [3:0]  opc;
        logic [63:0] len;
        reset_parser();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        write_reg(CFG_MAX_LENGTH, MAX_LENGTH_RESET);
        write_reg(CFG_REQUIRE_MASK, MAX_LENGTH_W'(1));
        @(negedge clk);
        queue_frame(OPC_TEXT, 64'd2, FORM_7, 1'b1, 32'h0, 1'b0);
        queue_byte(8'hff);
        queue_byte(8'h00);
        queue_frame(OPC_TEXT, 64'd0, FORM_7, 1'b1, 32'hffff_ffff, 1'b0);
        queue_frame(OPC_PING, 64'd0, FORM_7, 1'b1, 32'($urandom), 1'b0);
        queue_frame(OPC_PONG, 64'd1, FORM_7, 1'b1, 32'($urandom), 1'b1);
        wait_drained();

        while (bytes_queued < RANDOM_ITEMS)
        begin
            random_settings();
            @(negedge clk);
            phase_end = bytes_queued + $urandom_range(60, 140);
            while (bytes_queued < phase_end)
                queue_random_frame();
            wait_drained();
        end

        // closing frame that halts the parser, then bytes it must drop
        ending = ending_t'($urandom_range(0, 4));
        random_settings();
        if (ending == END_UNMASKED)
            write_reg(CFG_REQUIRE_MASK, MAX_LENGTH_W'(1));
        @(negedge clk);
        case (ending)
            END_CLOSE:
            begin
                queue_byte({4'($urandom), OPC_CLOSE});
            end
            END_UNMASKED:
            begin
                queue_frame(pick_data_opcode(), 64'($urandom_range(0, MAX_CONTROL_PAYLOAD)),
                            FORM_7, 1'b0, 32'h0, 1'b0);
            end
            END_TOO_LONG:
            begin
                if ($urandom_range(0, 1) == 0)
                    len = 64'(cfg_max_length) + 64'd1 + 64'($urandom_range(0, 255));
                else
                    len = {32'($urandom) | 32'h200, 32'($urandom)};
                queue_frame(pick_data_opcode(), len, FORM_64, 1'($urandom_range(0, 1)),
                            32'($urandom), 1'b0);
            end
            END_BAD_OPCODE:
            begin
                do
                    opc = 4'($urandom);
                while (opc == OPC_TEXT || opc == OPC_CLOSE || opc == OPC_PING ||
                       opc == OPC_PONG);
                queue_byte({4'($urandom), opc});
            end
            default:
            begin
                queue_frame(OPC_PING, 64'($urandom_range(MAX_CONTROL_PAYLOAD + 1, 65535)),
                            FORM_16, cfg_require_mask ? 1'b1 : 1'($urandom_range(0, 1)),
                            32'($urandom), 1'b0);
            end
        endcase
        repeat (20) queue_byte(8'($urandom));
        wait_drained();

        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
